>>> rtl/plm_pkg.sv
`default_nettype none

package plm_pkg;

   localparam int CHANNEL_BITS        = 6;
   localparam int LEVEL_BITS          = 15;
   localparam int COEF_BITS           = 16;
   localparam int CSR_DATA_BITS       = 32;
   localparam int CSR_ADDR_BITS       = 3;
   localparam int DEFAULT_CHANNELS    = 64;
   localparam int DEFAULT_SAMPLE_BITS = 16;

   localparam logic [COEF_BITS-1:0]  COEF_RESET  = 16'd3277;
   localparam logic [LEVEL_BITS-1:0] LEVEL_TOP   = 15'd20316;
   localparam logic [LEVEL_BITS-1:0] LEVEL_FLOOR = 15'd655;
   localparam logic [LEVEL_BITS-1:0] LEVEL_SPAN  = 15'd19661;
   localparam logic [10:0]           SLOPE_Q8    = 11'd1973;

   localparam logic [0:0] REG_DECAY_COEFFICIENT = 1'b0;

   localparam logic [7:0] FRAC_LOG [64] = '{
      8'd0,   8'd6,   8'd11,  8'd17,  8'd22,  8'd28,  8'd33,  8'd38,
      8'd44,  8'd49,  8'd54,  8'd59,  8'd63,  8'd68,  8'd73,  8'd78,
      8'd82,  8'd87,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113,
      8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
      8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd169, 8'd172, 8'd176,
      8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
      8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
      8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
   };

   typedef struct packed {
      logic clear_step;
      logic take;
      logic norm_step;
      logic log_step;
      logic level_step;
      logic decay_step;
      logic write_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic in_last_ok;
      logic norm_done;
      logic out_full;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/peak_level_meter_with_decay_core.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_tvalid/tready  | tdata: channel, sample; tlast: last_of_buffer
// rsp     | out       | rsp_tvalid/tready  | tdata: channel_out, level
// csr     | in        | APB psel/penable   | decay_coefficient at byte address 0
//
// A sample without the buffer mark only updates the running peak. A marked
// sample then passes through the bit-serial normalizer, one shift per leading
// zero of the peak (up to SAMPLE_BITS-2), and the two multiplier stages.
// After reset, the level memory is cleared entry by entry before req_tready rises.
// A waiting result stalls only the next marked sample, in its final write state.
`default_nettype none

module peak_level_meter_with_decay_core import plm_pkg::*; #(
   parameter int CHANNELS    = DEFAULT_CHANNELS,
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
   localparam int REQ_W      = ((CHANNEL_BITS + SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W      = ((CHANNEL_BITS + LEVEL_BITS + 7) / 8) * 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire [REQ_W-1:0]          req_tdata,  // channel, sample, zero pad
   input  wire                      req_tlast,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [RSP_W-1:0]         rsp_tdata,  // channel_out, level, zero pad
   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cmd_type                 cmd;
   sts_type                 sts;
   logic [COEF_BITS-1:0]    coef;
   logic [CHANNEL_BITS-1:0] rsp_channel;
   logic [LEVEL_BITS-1:0]   rsp_level;

   assign rsp_tdata = RSP_W'({rsp_level, rsp_channel});

   plm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   plm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   plm_dp #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .in_channel  (req_tdata[CHANNEL_BITS-1:0]),
      .in_sample   (req_tdata[CHANNEL_BITS +: SAMPLE_BITS]),
      .in_last     (req_tlast),
      .coef        (coef),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_channel (rsp_channel),
      .rsp_level   (rsp_level)
   );

endmodule

`default_nettype wire

>>> rtl/plm_csr.sv
`default_nettype none

module plm_csr import plm_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [COEF_BITS-1:0]     coef
);

   logic [COEF_BITS-1:0] coef_ff;
   logic [COEF_BITS-1:0] coef_in;
   logic                 hit;

   assign hit        = csr_paddr[2] == REG_DECAY_COEFFICIENT;
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         coef_in = csr_pwdata[COEF_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata = CSR_DATA_BITS'(coef_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/plm_ctrl.sv
`default_nettype none

module plm_ctrl import plm_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_tvalid,
   input  wire     rsp_tready,
   input  sts_type sts,
   output logic    req_tready,
   output cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_NORM  = 3'd2;
   localparam logic [2:0] ST_LOG   = 3'd3;
   localparam logic [2:0] ST_LEVEL = 3'd4;
   localparam logic [2:0] ST_DECAY = 3'd5;
   localparam logic [2:0] ST_WRITE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       out_free;

   assign out_free   = !sts.out_full || rsp_tready;
   assign req_tready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.take = req_tvalid;
            if (req_tvalid && sts.in_last_ok) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm_step = 1'b1;
            if (sts.norm_done) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            cmd.log_step = 1'b1;
            state_in     = ST_LEVEL;
         end
         ST_LEVEL: begin
            cmd.level_step = 1'b1;
            state_in       = ST_DECAY;
         end
         ST_DECAY: begin
            cmd.decay_step = 1'b1;
            state_in       = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               cmd.write_step = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/plm_dp.sv
`default_nettype none

module plm_dp import plm_pkg::*; #(
   parameter int CHANNELS    = DEFAULT_CHANNELS,
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input  wire                     clock,
   input  wire                     reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  wire [CHANNEL_BITS-1:0]  in_channel,
   input  wire [SAMPLE_BITS-1:0]   in_sample,
   input  wire                     in_last,
   input  wire [COEF_BITS-1:0]     coef,
   input  wire                     rsp_tready,
   output logic                    rsp_valid,
   output logic [CHANNEL_BITS-1:0] rsp_channel,
   output logic [LEVEL_BITS-1:0]   rsp_level
);

   localparam int PW     = SAMPLE_BITS - 1;
   localparam int EW     = $clog2(SAMPLE_BITS);
   localparam int LW     = EW + 8;
   localparam int M_TOP  = 256 * (SAMPLE_BITS - 1);
   localparam int MW     = $clog2(M_TOP + 1);
   localparam int PRODW  = MW + 11;
   localparam int RW     = PRODW - 7;
   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DPRODW = COEF_BITS + LEVEL_BITS;

   logic [LEVEL_BITS-1:0] mem [CHANNELS];

   logic [PW-1:0]           peak_ff;
   logic [PW-1:0]           peak_in;
   logic [PW-1:0]           norm_ff;
   logic [EW-1:0]           e_ff;
   logic                    zero_ff;
   logic [CHANNEL_BITS-1:0] ch_ff;
   logic [LEVEL_BITS-1:0]   rd_ff;
   logic [PRODW-1:0]        lprod_ff;
   logic [LEVEL_BITS-1:0]   newv_ff;
   logic                    dec_ff;
   logic [DPRODW-1:0]       dprod_ff;
   logic [IDX_W-1:0]        clr_ff;
   logic [IDX_W-1:0]        clr_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [CHANNEL_BITS-1:0] rsp_ch_ff;
   logic [LEVEL_BITS-1:0]   rsp_lvl_ff;

   logic                    in_ok;
   logic                    s_min;
   logic [SAMPLE_BITS-1:0]  neg;
   logic [PW-1:0]           mag;
   logic [PW-1:0]           peak_max;
   logic [IDX_W-1:0]        in_idx;
   logic [5:0]              frac_idx;
   logic [LW-1:0]           log_l;
   logic [MW-1:0]           m_val;
   logic [RW-1:0]           red;
   logic [LEVEL_BITS-1:0]   newv;
   logic [DPRODW:0]         sub_sum;
   logic [LEVEL_BITS-1:0]   sub;
   logic [LEVEL_BITS-1:0]   result;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_wa;
   logic [LEVEL_BITS-1:0]   mem_wd;

   assign in_ok    = 32'(in_channel) < CHANNELS;
   assign in_idx   = IDX_W'(in_channel);
   assign s_min    = in_sample == {1'b1, {PW{1'b0}}};
   assign neg      = ~in_sample + 1'b1;
   assign mag      = in_sample[SAMPLE_BITS-1] ? (s_min ? {PW{1'b1}} : neg[PW-1:0])
                                              : in_sample[PW-1:0];
   assign peak_max = (mag > peak_ff) ? mag : peak_ff;

   assign frac_idx = norm_ff[PW-2 -: 6];
   assign log_l    = {e_ff, 8'b0} + LW'(FRAC_LOG[frac_idx]);
   assign m_val    = MW'(M_TOP) - MW'(log_l);

   assign red  = RW'(((PRODW+1)'(lprod_ff) + (PRODW+1)'(128)) >> 8);
   assign newv = (zero_ff || red >= RW'(LEVEL_SPAN)) ? LEVEL_FLOOR
                                                      : LEVEL_TOP - red[LEVEL_BITS-1:0];

   assign sub_sum = (DPRODW+1)'(dprod_ff) + (DPRODW+1)'(17'h0FFFF);
   assign sub     = sub_sum[16 +: LEVEL_BITS];
   assign result  = dec_ff ? rd_ff - sub : newv_ff;

   assign sts.clear_last = clr_ff == IDX_W'(CHANNELS - 1);
   assign sts.in_last_ok = in_last && in_ok;
   assign sts.norm_done  = zero_ff || norm_ff[PW-1];
   assign sts.out_full   = rsp_valid_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_channel = rsp_ch_ff;
   assign rsp_level   = rsp_lvl_ff;

   always_comb begin
      peak_in = peak_ff;
      if (cmd.take && in_ok) begin
         peak_in = in_last ? '0 : peak_max;
      end
   end

   always_comb begin
      clr_in = clr_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      mem_we = cmd.clear_step || cmd.write_step;
      mem_wa = cmd.clear_step ? clr_ff : IDX_W'(ch_ff);
      mem_wd = cmd.clear_step ? '0 : result;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.take && in_ok && in_last) begin
         rd_ff <= mem[in_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && in_ok && in_last) begin
         norm_ff <= peak_max;
         zero_ff <= peak_max == '0;
         e_ff    <= EW'(PW - 1);
         ch_ff   <= in_channel;
      end else if (cmd.norm_step && !(zero_ff || norm_ff[PW-1])) begin
         norm_ff <= norm_ff << 1;
         e_ff    <= e_ff - 1'b1;
      end
      if (cmd.log_step) begin
         lprod_ff <= PRODW'(m_val) * PRODW'(SLOPE_Q8);
      end
      if (cmd.level_step) begin
         newv_ff <= newv;
      end
      if (cmd.decay_step) begin
         dec_ff   <= rd_ff > newv_ff;
         dprod_ff <= DPRODW'(coef) * DPRODW'(rd_ff - newv_ff);
      end
      if (cmd.write_step) begin
         rsp_ch_ff  <= ch_ff;
         rsp_lvl_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         peak_ff      <= peak_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire
